### rtl/trre_pkg.sv
// shared types, codes and constants of the tagged request retry engine
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package trre_pkg;

  localparam logic [2:0] OP_READ_RANGE = 3'd2;
  localparam logic [7:0] OP_LAST_VALID = 8'd3;

  localparam logic [7:0] CNT_LONG_A = 8'h82;
  localparam logic [7:0] CNT_LONG_B = 8'h83;
  localparam logic [7:0] CNT_LONG_C = 8'h85;

  localparam logic [15:0] SHORT_TIMEOUT_RESET = 16'd50;
  localparam logic [15:0] LONG_TIMEOUT_RESET  = 16'd5000;
  localparam logic [3:0]  MAX_ATTEMPTS_RESET  = 4'd3;
  localparam logic [7:0]  TAG_RESET           = 8'd1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_RESP  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_FAIL  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    REG_SHORT_TIMEOUT = 2'd0,
    REG_LONG_TIMEOUT  = 2'd1,
    REG_MAX_ATTEMPTS  = 2'd2,
    REG_NONE          = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_INVALID   = 3'd1,
    RC_BUSY      = 3'd2,
    RC_TIMEOUT   = 3'd3,
    RC_SEND_FAIL = 3'd4
  } result_code_t;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [2:0] {
    CMD_START_BAD = 3'd0,
    CMD_START     = 3'd1,
    CMD_RESP      = 3'd2,
    CMD_RESP_DROP = 3'd3,
    CMD_TICK      = 3'd4,
    CMD_FAIL      = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] frame_base;
    logic        long_timeout;
    logic        single_attempt;
    logic [2:0]  rop;
    logic [7:0]  tag;
    logic [3:0]  status;
    logic [2:0]  count;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] short_timeout_ms;
    logic [15:0] long_timeout_ms;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic         out_kind;
    logic [63:0]  frame;
    result_code_t result_code;
    logic [2:0]   done_op;
    logic [7:0]   done_tag;
    logic [3:0]   done_status;
    logic [2:0]   done_count;
    logic [31:0]  done_data;
  } res_t;

endpackage

`default_nettype wire

### rtl/tagged_request_retry_engine.sv
// top level of the tagged request retry engine
// depends on trre_pkg, trre_regs, trre_front, trre_cmd_queue, trre_back
//
//   channel   handshake          payload
//   input     push / full        req_type .. resp_data
//   result    empty / pop        out_kind .. done_data
//   config    apb, pready = 1    paddr[3:2] selects register
//
// one item per cycle sustained while full is low; an item's result, if any,
// is written into the result queue from the head of the command queue and can
// be popped once it is on the result ports; the back end handles one command
// per cycle and stalls only when the two-entry result queue is full and not
// popped; the four-entry command queue then fills and raises full
// synchronous reset empties both queues and restores register defaults
`timescale 1ns / 1ps
`default_nettype none

module tagged_request_retry_engine (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   req_type,
  input  wire logic [7:0]                   op,
  input  wire logic [15:0]                  address,
  input  wire logic [7:0]                   value_or_count,
  input  wire logic [15:0]                  write_address,
  input  wire logic [7:0]                   write_value,
  input  wire logic                         single_attempt,
  input  wire logic [7:0]                   resp_tag,
  input  wire logic [7:0]                   resp_status_raw,
  input  wire logic [3:0]                   resp_length,
  input  wire logic [7:0]                   resp_count,
  input  wire logic [31:0]                  resp_data,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              out_kind,
  output logic [63:0]                       frame,
  output logic [2:0]                        result_code,
  output logic [2:0]                        done_op,
  output logic [7:0]                        done_tag,
  output logic [3:0]                        done_status,
  output logic [2:0]                        done_count,
  output logic [31:0]                       done_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [trre_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  trre_pkg::cfg_t cfg;
  trre_pkg::cmd_t in_cmd;
  trre_pkg::cmd_t head_cmd;
  trre_pkg::res_t res;
  logic           cmd_empty;
  logic           cmd_pop;

  trre_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trre_front u_front (
    .req_type        (req_type),
    .op              (op),
    .address         (address),
    .value_or_count  (value_or_count),
    .write_address   (write_address),
    .write_value     (write_value),
    .single_attempt  (single_attempt),
    .resp_tag        (resp_tag),
    .resp_status_raw (resp_status_raw),
    .resp_length     (resp_length),
    .resp_count      (resp_count),
    .resp_data       (resp_data),
    .cmd             (in_cmd)
  );

  trre_cmd_queue u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (in_cmd),
    .full     (full),
    .pop      (cmd_pop),
    .head     (head_cmd),
    .empty    (cmd_empty)
  );

  trre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (head_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_kind    = res.out_kind;
  assign frame       = res.frame;
  assign result_code = res.result_code;
  assign done_op     = res.done_op;
  assign done_tag    = res.done_tag;
  assign done_status = res.done_status;
  assign done_count  = res.done_count;
  assign done_data   = res.done_data;

endmodule

`default_nettype wire

### rtl/trre_regs.sv
// apb configuration registers: timeouts and attempt limit
// depends on trre_pkg
`timescale 1ns / 1ps
`default_nettype none

module trre_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [trre_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output trre_pkg::cfg_t                   cfg
);

  trre_pkg::reg_index_t idx;
  logic                 wr;

  assign idx    = trre_pkg::reg_index_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_timeout_ms <= trre_pkg::SHORT_TIMEOUT_RESET;
      cfg.long_timeout_ms  <= trre_pkg::LONG_TIMEOUT_RESET;
      cfg.max_attempts     <= trre_pkg::MAX_ATTEMPTS_RESET;
    end else if (wr) begin
      case (idx)
        trre_pkg::REG_SHORT_TIMEOUT: cfg.short_timeout_ms <= pwdata[15:0];
        trre_pkg::REG_LONG_TIMEOUT:  cfg.long_timeout_ms  <= pwdata[15:0];
        trre_pkg::REG_MAX_ATTEMPTS:  cfg.max_attempts     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      trre_pkg::REG_SHORT_TIMEOUT: prdata = {16'd0, cfg.short_timeout_ms};
      trre_pkg::REG_LONG_TIMEOUT:  prdata = {16'd0, cfg.long_timeout_ms};
      trre_pkg::REG_MAX_ATTEMPTS:  prdata = {28'd0, cfg.max_attempts};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/trre_front.sv
// front end: decodes and classifies one incoming item into a command
// depends on trre_pkg; feeds trre_cmd_queue
`timescale 1ns / 1ps
`default_nettype none

module trre_front (
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  op,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  value_or_count,
  input  wire logic [15:0] write_address,
  input  wire logic [7:0]  write_value,
  input  wire logic        single_attempt,
  input  wire logic [7:0]  resp_tag,
  input  wire logic [7:0]  resp_status_raw,
  input  wire logic [3:0]  resp_length,
  input  wire logic [7:0]  resp_count,
  input  wire logic [31:0] resp_data,
  output trre_pkg::cmd_t   cmd
);

  trre_pkg::req_type_t rt;
  logic                resp_ok;
  logic [3:0]          len_expect;

  assign rt         = trre_pkg::req_type_t'(req_type);
  assign len_expect = {1'b0, resp_count[2:0]} + 4'd4;
  assign resp_ok    = (resp_count <= 8'd4) && (resp_length == len_expect);

  always_comb begin
    cmd.frame_base = {write_value, write_address[7:0], write_address[15:8],
                      value_or_count, address[7:0], address[15:8], 8'd0, op};
    cmd.long_timeout = (op[7:0] == {5'd0, trre_pkg::OP_READ_RANGE}) &&
                       ((value_or_count == trre_pkg::CNT_LONG_A) ||
                        (value_or_count == trre_pkg::CNT_LONG_B) ||
                        (value_or_count == trre_pkg::CNT_LONG_C));
    cmd.single_attempt = single_attempt;
    cmd.rop    = op[2:0];
    cmd.tag    = resp_tag;
    cmd.status = resp_status_raw[3:0];
    cmd.count  = resp_count[2:0];
    case (resp_count[2:0])
      3'd0:    cmd.data = 32'd0;
      3'd1:    cmd.data = {24'd0, resp_data[7:0]};
      3'd2:    cmd.data = {16'd0, resp_data[15:0]};
      3'd3:    cmd.data = {8'd0, resp_data[23:0]};
      default: cmd.data = resp_data;
    endcase
    case (rt)
      trre_pkg::REQ_START:
        cmd.kind = (op > trre_pkg::OP_LAST_VALID) ? trre_pkg::CMD_START_BAD
                                                  : trre_pkg::CMD_START;
      trre_pkg::REQ_RESP:
        cmd.kind = resp_ok ? trre_pkg::CMD_RESP : trre_pkg::CMD_RESP_DROP;
      trre_pkg::REQ_TICK: cmd.kind = trre_pkg::CMD_TICK;
      default:            cmd.kind = trre_pkg::CMD_FAIL;
    endcase
  end

endmodule

`default_nettype wire

### rtl/trre_cmd_queue.sv
// short command queue between front and back end
// depends on trre_pkg
`timescale 1ns / 1ps
`default_nettype none

module trre_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  trre_pkg::cmd_t      push_cmd,
  output logic                full,
  input  wire logic           pop,
  output trre_pkg::cmd_t      head,
  output logic                empty
);

  localparam int AW = trre_pkg::CMDQ_AW;

  trre_pkg::cmd_t  mem [trre_pkg::CMDQ_DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (AW+1)'(trre_pkg::CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/trre_back.sv
// back end: transaction state, tag, retry counting and result queue
// depends on trre_pkg; takes commands from trre_cmd_queue
`timescale 1ns / 1ps
`default_nettype none

module trre_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  trre_pkg::cfg_t cfg,
  input  trre_pkg::cmd_t cmd,
  input  wire logic      cmd_empty,
  output logic           cmd_pop,
  input  wire logic      pop,
  output logic           empty,
  output trre_pkg::res_t res
);

  localparam int AW = trre_pkg::RESQ_AW;

  logic        busy, busy_next;
  logic [7:0]  next_tag, next_tag_next;
  logic [63:0] held_frame, held_frame_next;
  logic [3:0]  attempts_left, attempts_left_next;
  logic [15:0] wait_ticks, wait_ticks_next;
  logic        use_long, use_long_next;

  trre_pkg::res_t rq [trre_pkg::RESQ_DEPTH];
  logic [AW-1:0]  wptr, rptr;
  logic [AW:0]    count;
  logic           res_valid;
  trre_pkg::res_t res_new;
  logic           go, rq_push, rq_pop;
  logic [15:0]    tmo_sel;
  logic [15:0]    tmo;
  logic [63:0]    start_frame;
  logic [3:0]     start_left;

  assign rq_pop  = pop && !empty;
  assign empty   = (count == '0);
  assign go      = !cmd_empty &&
                   ((count != (AW+1)'(trre_pkg::RESQ_DEPTH)) || rq_pop);
  assign cmd_pop = go;
  assign rq_push = go && res_valid;
  assign res     = rq[rptr];

  assign start_frame = {cmd.frame_base[63:16], next_tag, cmd.frame_base[7:0]};
  assign start_left  = (cmd.single_attempt || cfg.max_attempts == 4'd0) ? 4'd0
                                                                        : cfg.max_attempts - 4'd1;

  always_comb begin
    tmo_sel = use_long_next ? cfg.long_timeout_ms : cfg.short_timeout_ms;
    tmo     = (tmo_sel == 16'd0) ? 16'd1 : tmo_sel;
  end

  always_comb begin
    busy_next          = busy;
    next_tag_next      = next_tag;
    held_frame_next    = held_frame;
    attempts_left_next = attempts_left;
    wait_ticks_next    = wait_ticks;
    use_long_next      = use_long;
    res_valid          = 1'b0;
    res_new            = '0;
    case (cmd.kind)
      trre_pkg::CMD_START_BAD: begin
        res_valid           = 1'b1;
        res_new.out_kind    = trre_pkg::KIND_DONE;
        res_new.result_code = trre_pkg::RC_INVALID;
      end
      trre_pkg::CMD_START: begin
        res_valid = 1'b1;
        if (busy) begin
          res_new.out_kind    = trre_pkg::KIND_DONE;
          res_new.result_code = trre_pkg::RC_BUSY;
        end else begin
          use_long_next      = cmd.long_timeout;
          held_frame_next    = start_frame;
          next_tag_next      = next_tag + 8'd1;
          attempts_left_next = start_left;
          wait_ticks_next    = tmo;
          busy_next          = 1'b1;
          res_new.out_kind   = trre_pkg::KIND_FRAME;
          res_new.frame      = start_frame;
        end
      end
      trre_pkg::CMD_RESP: begin
        if (busy && cmd.tag == held_frame[15:8] &&
            {5'd0, cmd.rop} == held_frame[7:0]) begin
          busy_next           = 1'b0;
          res_valid           = 1'b1;
          res_new.out_kind    = trre_pkg::KIND_DONE;
          res_new.result_code = trre_pkg::RC_OK;
          res_new.done_op     = cmd.rop;
          res_new.done_tag    = cmd.tag;
          res_new.done_status = cmd.status;
          res_new.done_count  = cmd.count;
          res_new.done_data   = cmd.data;
        end
      end
      trre_pkg::CMD_TICK: begin
        if (busy) begin
          if (wait_ticks > 16'd1) begin
            wait_ticks_next = wait_ticks - 16'd1;
          end else if (attempts_left != 4'd0) begin
            attempts_left_next = attempts_left - 4'd1;
            wait_ticks_next    = tmo;
            res_valid          = 1'b1;
            res_new.out_kind   = trre_pkg::KIND_FRAME;
            res_new.frame      = held_frame;
          end else begin
            busy_next           = 1'b0;
            wait_ticks_next     = 16'd0;
            res_valid           = 1'b1;
            res_new.out_kind    = trre_pkg::KIND_DONE;
            res_new.result_code = trre_pkg::RC_TIMEOUT;
          end
        end
      end
      trre_pkg::CMD_FAIL: begin
        if (busy) begin
          busy_next           = 1'b0;
          wait_ticks_next     = 16'd0;
          attempts_left_next  = 4'd0;
          res_valid           = 1'b1;
          res_new.out_kind    = trre_pkg::KIND_DONE;
          res_new.result_code = trre_pkg::RC_SEND_FAIL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      next_tag      <= trre_pkg::TAG_RESET;
      held_frame    <= 64'd0;
      attempts_left <= 4'd0;
      wait_ticks    <= 16'd0;
      use_long      <= 1'b0;
    end else if (go) begin
      busy          <= busy_next;
      next_tag      <= next_tag_next;
      held_frame    <= held_frame_next;
      attempts_left <= attempts_left_next;
      wait_ticks    <= wait_ticks_next;
      use_long      <= use_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[wptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (rq_push) begin
        wptr <= wptr + 1'b1;
      end
      if (rq_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({rq_push, rq_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/trre_checker.sv
// port-level checks of the tagged request retry engine, bound to the top level
// depends on tagged_request_retry_engine and trre_pkg
`timescale 1ns / 1ps
`default_nettype none

module trre_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        out_kind,
  input wire logic [63:0] frame,
  input wire logic [2:0]  result_code,
  input wire logic [2:0]  done_count,
  input wire logic [31:0] done_data
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_frame_code: assert property (@(posedge clk) disable iff (rst)
      (!empty && out_kind == trre_pkg::KIND_FRAME) |-> (result_code == trre_pkg::RC_OK))
    else $error("frame item with nonzero result code");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
      (!empty && out_kind == trre_pkg::KIND_DONE && result_code != trre_pkg::RC_OK)
      |-> (done_data == 32'd0 && done_count == 3'd0 && frame == 64'd0))
    else $error("failed completion carries data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(frame) && $stable(done_data)))
    else $error("stalled result changed");

endmodule

bind tagged_request_retry_engine trre_checker u_trre_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_kind    (out_kind),
  .frame       (frame),
  .result_code (result_code),
  .done_count  (done_count),
  .done_data   (done_data)
);

`default_nettype wire
